/* rtl/lmcs_pkg.sv */
`default_nettype none

package lmcs_pkg;

  localparam int COLUMNS    = 22;
  localparam int SLOT_TICKS = 6;

  localparam int COL_W    = $clog2(COLUMNS);
  localparam int SLOT_W   = $clog2(SLOT_TICKS);
  localparam int DRIVE_W  = 22;
  localparam int ROW_W    = 7;
  localparam int IDX_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int BRIGHT_W = 3;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd2;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ACT_HOLD  = 3'b001,
    ACT_BLANK = 3'b010,
    ACT_LOAD  = 3'b100
  } drive_act_t;

  typedef struct packed {
    drive_act_t       act;
    logic             flip;
    logic [COL_W-1:0] scan;
    logic             started;
  } drive_cmd_t;

  function automatic logic [ROW_W-1:0] reverse_rows(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    for (int i = 0; i < ROW_W; i++) begin
      r[ROW_W-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/lmcs_if.sv */
`default_nettype none

interface lmcs_in_if import lmcs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [IDX_W-1:0]  column_index;
  logic [BYTE_W-1:0] column_byte;
  logic              orientation_switch;

  modport source (output valid, cmd, column_index, column_byte, orientation_switch,
                  input ready);
  modport sink   (input valid, cmd, column_index, column_byte, orientation_switch,
                  output ready);
endinterface

interface lmcs_out_if import lmcs_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] column_drive;
  logic [ROW_W-1:0]   row_drive;
  logic               frame_started;

  modport source (output valid, column_drive, row_drive, frame_started, input ready);
  modport sink   (input valid, column_drive, row_drive, frame_started, output ready);
endinterface

interface lmcs_cfg_if import lmcs_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness;

  modport source (output valid, brightness, input ready);
  modport sink   (input valid, brightness, output ready);
endinterface

`default_nettype wire

/* rtl/lmcs_column_ram.sv */
`default_nettype none

module lmcs_column_ram import lmcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [COL_W-1:0]  wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [COL_W-1:0]  rd_addr,
  output logic      [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [COLUMNS];
  logic [COLUMNS-1:0] valid_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

/* rtl/lmcs_scan_ctrl.sv */
`default_nettype none

module lmcs_scan_ctrl import lmcs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lmcs_cfg_if.sink              cfg_ch,
  input  wire logic             tick_fire,
  input  wire logic             sw,
  output drive_cmd_t            cmd_nxt,
  output logic      [COL_W-1:0] scan
);

  logic [BRIGHT_W-1:0] brightness_r;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [COL_W-1:0]    scan_r, scan_nxt;
  logic                flipped_r, flipped_nxt;
  logic                started_r, started_nxt;

  assign cfg_ch.ready = 1'b1;
  assign scan         = scan_r;

  always_comb begin
    slot_nxt     = slot_r;
    scan_nxt     = scan_r;
    flipped_nxt  = flipped_r;
    started_nxt  = started_r;
    cmd_nxt.act  = ACT_HOLD;
    cmd_nxt.flip = flipped_r;
    cmd_nxt.scan = scan_r;
    if (tick_fire) begin
      if (int'(slot_r) < SLOT_TICKS - 1) begin
        if (int'(slot_r) == int'(brightness_r)) begin
          cmd_nxt.act = ACT_BLANK;
        end
        slot_nxt = slot_r + 1'b1;
      end else begin
        slot_nxt    = '0;
        cmd_nxt.act = ACT_LOAD;
        if (int'(scan_r) >= COLUMNS - 1) begin
          scan_nxt    = '0;
          flipped_nxt = sw;
          started_nxt = 1'b1;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
    end
    cmd_nxt.started = started_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RESET;
      slot_r       <= '0;
      scan_r       <= '0;
      flipped_r    <= 1'b0;
      started_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        brightness_r <= cfg_ch.brightness;
      end
      slot_r    <= slot_nxt;
      scan_r    <= scan_nxt;
      flipped_r <= flipped_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lmcs_drive.sv */
`default_nettype none

module lmcs_drive import lmcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire drive_cmd_t         cmd_in,
  input  wire logic               advance,
  input  wire logic [BYTE_W-1:0]  rd_data,
  output logic      [DRIVE_W-1:0] column_drive,
  output logic      [ROW_W-1:0]   row_drive,
  output logic                    frame_started
);

  drive_cmd_t         cmd_r;
  logic [DRIVE_W-1:0] col_r, col_nxt, col_onehot;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               started_r;
  logic [COL_W-1:0]   pos;

  assign pos = cmd_r.flip ? cmd_r.scan : COL_W'(COLUMNS - 1) - cmd_r.scan;

  always_comb begin
    for (int n = 0; n < DRIVE_W; n++) begin
      col_onehot[n] = (int'(pos) == n);
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    case (cmd_r.act)
      ACT_HOLD: begin
      end
      ACT_BLANK: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      ACT_LOAD: begin
        col_nxt = col_onehot;
        row_nxt = cmd_r.flip ? reverse_rows(rd_data[ROW_W-1:0]) : rd_data[ROW_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      started_r <= 1'b0;
    end else if (advance) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      started_r <= cmd_r.started;
    end
  end

  assign column_drive  = col_r;
  assign row_drive     = row_r;
  assign frame_started = started_r;

endmodule

`default_nettype wire

/* rtl/led_matrix_column_scanner.sv */
// LED matrix column scanner with PWM dimming.
//
// in_ch  : one beat per item; cmd 1 writes column_byte to column_index
//          (indexes past the last column are dropped), cmd 0 is a refresh
//          tick that steps the slot counter and the column scan.
// out_ch : one beat per input beat, in order: column_drive, row_drive and
//          frame_started as they stand after that item.
// cfg_ch : brightness write, always ready; write only while idle.
//
// An input beat reaches out_ch through the column memory read issued at
// acceptance, then the drive latch update. Throughput is one item per
// cycle while out_ch is not stalled. A stalled output holds its beat; one
// more item is taken into the middle stage and then in_ch.ready drops
// until out_ch is drained. Reset clears the column memory valid bits
// (columns read as zero), the scan and slot counters, the latches and
// brightness back to 2; in_ch.ready is high as soon as reset is released.
`default_nettype none

module led_matrix_column_scanner import lmcs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  lmcs_in_if.sink   in_ch,
  lmcs_out_if.source out_ch,
  lmcs_cfg_if.sink  cfg_ch
);

  logic             s1_valid_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_fire;
  logic             tick_fire;
  logic             wr_en;
  logic [BYTE_W-1:0] rd_data;
  logic [COL_W-1:0] scan;
  drive_cmd_t       cmd_nxt;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign tick_fire   = in_fire && (in_ch.cmd == CMD_TICK);
  assign wr_en       = in_fire && (in_ch.cmd == CMD_WRITE)
                       && (int'(in_ch.column_index) < COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  lmcs_scan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .tick_fire (tick_fire),
    .sw        (in_ch.orientation_switch),
    .cmd_nxt   (cmd_nxt),
    .scan      (scan)
  );

  lmcs_column_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (COL_W'(in_ch.column_index)),
    .wr_data (in_ch.column_byte),
    .rd_en   (tick_fire),
    .rd_addr (scan),
    .rd_data (rd_data)
  );

  lmcs_drive u_drive (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_fire),
    .cmd_in        (cmd_nxt),
    .advance       (advance),
    .rd_data       (rd_data),
    .column_drive  (out_ch.column_drive),
    .row_drive     (out_ch.row_drive),
    .frame_started (out_ch.frame_started)
  );

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
  import lmcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 4;
  localparam int REPORT_MAX  = 10;
  localparam int IDX_TOP     = (1 << IDX_W) - 1;

  typedef struct packed {
    logic [DRIVE_W-1:0] column_drive;
    logic [ROW_W-1:0]   row_drive;
    logic               frame_started;
  } scan_result_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  lmcs_in_if  in_ch ();
  lmcs_out_if out_ch ();
  lmcs_cfg_if cfg_ch ();

  led_matrix_column_scanner uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the scanner state
  logic [BYTE_W-1:0]   mem_shadow [COLUMNS];
  logic [SLOT_W-1:0]   slot_cnt;
  logic [IDX_W-1:0]    scan_pos;
  logic                flip_q;
  logic                started_q;
  logic [DRIVE_W-1:0]  col_latch_q;
  logic [ROW_W-1:0]    row_latch_q;
  logic [BRIGHT_W-1:0] bright_q;

  scan_result_t drive_exp_q [$];

  int  err_count    = 0;
  int  stall_cycles = 0;
  int  burst_left   = 0;
  bit  tx_steady    = 1'b0;
  bit  hold_toggle  = 1'b0;
  bit  hold_seen    = 1'b0;

  function automatic scan_result_t predict_drive(input logic cmd,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [BYTE_W-1:0] cb,
                                                 input logic sw);
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  pos;
    logic [ROW_W-1:0]  rev;
    scan_result_t      res;
    if (cmd == CMD_WRITE) begin
      if (idx < COLUMNS) mem_shadow[idx] = cb;
    end else if (slot_cnt < SLOT_TICKS - 1) begin
      // early blank sets the duty cycle
      if (slot_cnt == bright_q) begin
        col_latch_q = '0;
        row_latch_q = '0;
      end
      slot_cnt = slot_cnt + 1'b1;
    end else begin
      slot_cnt = '0;
      col_latch_q = '0;
      if (scan_pos >= COLUMNS) scan_pos = '0;
      data = mem_shadow[scan_pos];
      for (int i = 0; i < ROW_W; i++) rev[ROW_W-1-i] = data[i];
      if (!flip_q) begin
        pos = IDX_W'(COLUMNS - 1 - scan_pos);
        row_latch_q = data[ROW_W-1:0];
      end else begin
        pos = scan_pos;
        row_latch_q = rev;
      end
      col_latch_q[pos] = 1'b1;
      scan_pos = scan_pos + 1'b1;
      if (scan_pos >= COLUMNS) begin
        scan_pos  = '0;
        flip_q    = sw;
        started_q = 1'b1;
      end
    end
    res.column_drive  = col_latch_q;
    res.row_drive     = row_latch_q;
    res.frame_started = started_q;
    return res;
  endfunction

  task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] cb, input logic sw);
    int gap;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_ch.valid              <= 1'b1;
    in_ch.cmd                <= cmd;
    in_ch.column_index       <= idx;
    in_ch.column_byte        <= cb;
    in_ch.orientation_switch <= sw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    drive_exp_q.push_back(predict_drive(cmd, idx, cb, sw));
  endtask

  task automatic send_random_item();
    logic             cmd;
    logic [IDX_W-1:0] idx;
    cmd = ($urandom_range(0, 99) < 22) ? CMD_WRITE : CMD_TICK;
    if ($urandom_range(0, 7) == 0) idx = IDX_W'($urandom_range(COLUMNS, IDX_TOP));
    else idx = IDX_W'($urandom_range(0, COLUMNS - 1));
    send_item(cmd, idx, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drive_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_brightness(input logic [BRIGHT_W-1:0] v);
    wait_results_drained();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.brightness <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    bright_q = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // column writes incl. dropped indexes, refresh ticks at reset brightness,
  // then brightness 7 which never blanks early
  task automatic test_directed();
    send_item(CMD_WRITE, 0, 8'hFF, 1'b0);
    send_item(CMD_WRITE, IDX_W'(COLUMNS - 1), 8'h80, 1'b1);
    send_item(CMD_WRITE, 10, 8'h01, 1'b0);
    send_item(CMD_WRITE, 5, 8'h40, 1'b1);
    send_item(CMD_WRITE, IDX_W'(COLUMNS), 8'hAA, 1'b0);
    send_item(CMD_WRITE, IDX_W'(IDX_TOP), 8'hFF, 1'b1);
    send_item(CMD_WRITE, 1, 8'h55, 1'b0);
    for (int i = 0; i < 9; i++) send_item(CMD_TICK, IDX_W'(IDX_TOP), 8'hFF, i[0]);
    write_brightness(3'd7);
    for (int i = 0; i < 6; i++) send_item(CMD_TICK, 0, 8'h00, 1'b1);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_toggle <= ~hold_toggle;
    tx_steady = 1'b1;
    for (int i = 0; i < 40; i++) send_random_item();
    tx_steady = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_sweep();
    logic [BRIGHT_W-1:0] levels [8];
    levels = '{3'd5, 3'd0, 3'd7, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2};
    foreach (levels[k]) begin
      write_brightness(levels[k]);
      for (int i = 0; i < 200; i++) send_random_item();
    end
  endtask

  initial begin
    for (int i = 0; i < COLUMNS; i++) mem_shadow[i] = '0;
    slot_cnt    = '0;
    scan_pos    = '0;
    flip_q      = 1'b0;
    started_q   = 1'b0;
    col_latch_q = '0;
    row_latch_q = '0;
    bright_q    = BRIGHT_RESET;

    rst_n                    <= 1'b0;
    in_ch.valid              <= 1'b0;
    in_ch.cmd                <= CMD_TICK;
    in_ch.column_index       <= '0;
    in_ch.column_byte        <= '0;
    in_ch.orientation_switch <= 1'b0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.brightness        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_sweep();
    wait_results_drained();

    if (err_count == 0 && drive_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: rotating stall patterns plus a long hold on request
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    int       hold_left;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ((phase % 8) >= 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_drive
    scan_result_t want;
    scan_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.column_drive  = out_ch.column_drive;
      got.row_drive     = out_ch.row_drive;
      got.frame_started = out_ch.frame_started;
      if (drive_exp_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected beat: col %h row %h started %b",
                   got.column_drive, got.row_drive, got.frame_started);
      end else begin
        want = drive_exp_q.pop_front();
        if (got.column_drive !== want.column_drive ||
            got.row_drive !== want.row_drive ||
            got.frame_started !== want.frame_started) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display("mismatch: exp col %h row %h started %b, got col %h row %h started %b",
                     want.column_drive, want.row_drive, want.frame_started,
                     got.column_drive, got.row_drive, got.frame_started);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
